// ----- src/u8d_pkg.sv -----
package u8d_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned CodeW    = 21;
   localparam int unsigned PartialW = 18;
   localparam int unsigned PendW    = 2;

   // Byte patterns of the lead position
   localparam logic [ByteW-1:0] AsciiMax   = 8'h7F;
   localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
   localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
   localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
   localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
   localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
   localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;
   localparam logic [ByteW-1:0] Lead2Bits  = 8'h1F;
   localparam logic [ByteW-1:0] Lead3Bits  = 8'h0F;
   localparam logic [ByteW-1:0] Lead4Bits  = 8'h07;

   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_STRAY
   } lead_kind_type;

   function automatic lead_kind_type lead_kind(input logic [ByteW-1:0] c);
      lead_kind_type k;
      if (c <= AsciiMax) begin
         k = LEAD_ASCII;
      end else if ((c & Lead2Mask) == Lead2Code) begin
         k = LEAD_TWO;
      end else if ((c & Lead3Mask) == Lead3Code) begin
         k = LEAD_THREE;
      end else if ((c & Lead4Mask) == Lead4Code) begin
         k = LEAD_FOUR;
      end else begin
         k = LEAD_STRAY;
      end
      return k;
   endfunction

endpackage

// ----- src/u8d_stream_if.sv -----
interface u8d_req_if
   import u8d_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             final_byte;

   modport source (output valid, data_byte, final_byte, input ready);
   modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface u8d_rsp_if
   import u8d_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CodeW-1:0] code_point;
   logic             string_end;
   logic             truncated;

   modport source (output valid, code_point, string_end, truncated, input ready);
   modport sink   (input valid, code_point, string_end, truncated, output ready);
endinterface

// ----- src/utf8_byte_stream_decoder.sv -----
// channel  | dir | payload                                   | handshake
// ---------+-----+-------------------------------------------+-------------
// req_ch   | in  | data_byte[7:0], final_byte                | valid/ready
// rsp_ch   | out | code_point[20:0], string_end, truncated   | valid/ready
//
// One byte per cycle while rsp_ch is not stalled; a result appears on rsp_ch the cycle after its byte.
// Latency and throughput are set by the single result register.
// Reset (synchronous) clears the pending count, partial value and rsp valid.
// req_ch.ready is low only while a result is held and rsp_ch.ready is low.
// Bytes that give no result (lead of a sequence, inner continuation) pass
// without touching the result register.
module utf8_byte_stream_decoder
   import u8d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u8d_req_if.sink     req_ch,
   u8d_rsp_if.source   rsp_ch
);

   logic [PendW-1:0]    bytes_pending_ff, bytes_pending_in;
   logic [PartialW-1:0] partial_value_ff, partial_value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CodeW-1:0]    code_point_ff, code_point_in;
   logic                string_end_ff, string_end_in;
   logic                truncated_ff, truncated_in;

   logic                accept;
   logic                emit;
   logic [CodeW-1:0]    emit_cp;
   logic                emit_trunc;
   lead_kind_type       kind;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign kind         = lead_kind(req_ch.data_byte);

   // decode one byte
   always_comb begin
      bytes_pending_in = bytes_pending_ff;
      partial_value_in = partial_value_ff;
      emit             = 1'b0;
      emit_cp          = '0;
      emit_trunc       = 1'b0;
      if (bytes_pending_ff != '0) begin
         bytes_pending_in = bytes_pending_ff - PendW'(1);
         if (bytes_pending_ff == PendW'(1)) begin
            partial_value_in = '0;
            emit             = 1'b1;
            emit_cp          = {partial_value_ff[CodeW-7:0], req_ch.data_byte[5:0]};
         end else begin
            partial_value_in = {partial_value_ff[PartialW-7:0], req_ch.data_byte[5:0]};
            emit_trunc       = 1'b1;
         end
      end else begin
         unique case (kind)
            LEAD_ASCII: begin
               emit    = 1'b1;
               emit_cp = CodeW'(req_ch.data_byte);
            end
            LEAD_TWO: begin
               bytes_pending_in = PendW'(1);
               partial_value_in = PartialW'(req_ch.data_byte & Lead2Bits);
               emit_trunc       = 1'b1;
            end
            LEAD_THREE: begin
               bytes_pending_in = PendW'(2);
               partial_value_in = PartialW'(req_ch.data_byte & Lead3Bits);
               emit_trunc       = 1'b1;
            end
            LEAD_FOUR: begin
               bytes_pending_in = PendW'(3);
               partial_value_in = PartialW'(req_ch.data_byte & Lead4Bits);
               emit_trunc       = 1'b1;
            end
            default: begin
               emit_trunc = 1'b1;
            end
         endcase
      end
      // end of string: always one result, drop any partial tail
      if (req_ch.final_byte) begin
         bytes_pending_in = '0;
         partial_value_in = '0;
         if (emit_trunc) begin
            emit    = 1'b1;
            emit_cp = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      code_point_in = code_point_ff;
      string_end_in = string_end_ff;
      truncated_in  = truncated_ff;
      if (accept && emit) begin
         rsp_valid_in  = 1'b1;
         code_point_in = emit_cp;
         string_end_in = req_ch.final_byte;
         truncated_in  = req_ch.final_byte && emit_trunc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff <= '0;
         partial_value_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            bytes_pending_ff <= bytes_pending_in;
            partial_value_ff <= partial_value_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_point_ff <= code_point_in;
      string_end_ff <= string_end_in;
      truncated_ff  <= truncated_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.code_point = code_point_ff;
   assign rsp_ch.string_end = string_end_ff;
   assign rsp_ch.truncated  = truncated_ff;

`ifndef SYNTHESIS
   a_trunc_zero_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && truncated_ff |-> code_point_ff == '0 && string_end_ff)
      else $error("truncated result carries a code point or lacks string end");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.final_byte |=> bytes_pending_ff == '0 && partial_value_ff == '0)
      else $error("state not cleared after final byte");

   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      bytes_pending_ff == '0 |-> partial_value_ff == '0)
      else $error("partial value left without pending bytes");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("byte taken while result is stalled");

   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.final_byte |=> rsp_valid_ff && string_end_ff)
      else $error("final byte gave no end-of-string result");
`endif

endmodule

// ----- test/utf8_byte_stream_decoder_test.sv -----
module utf8_byte_stream_decoder_test
   import u8d_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CodeW-1:0] code_point;
      logic             string_end;
      logic             truncated;
   } code_point_item_type;

   class utf8_decode_tracker_type;
      logic [PendW-1:0]    pending;
      logic [PartialW-1:0] partial;
      code_point_item_type decoded_fifo[$];
      int                  errors;

      function new();
         pending = '0;
         partial = '0;
         errors  = 0;
      endfunction

      task report(input string what);
         $display("%0t ns: mismatch: %s", $time, what);
         errors++;
      endtask

      function lead_kind_type classify_lead(input logic [ByteW-1:0] c);
         if (c <= AsciiMax) begin
            return LEAD_ASCII;
         end else if ((c & Lead2Mask) == Lead2Code) begin
            return LEAD_TWO;
         end else if ((c & Lead3Mask) == Lead3Code) begin
            return LEAD_THREE;
         end else if ((c & Lead4Mask) == Lead4Code) begin
            return LEAD_FOUR;
         end
         return LEAD_STRAY;
      endfunction

      // Note an accepted byte and queue the code point it completes, if any.
      function void take_byte(input logic [ByteW-1:0] c, input logic last);
         logic [PartialW+5:0] grown;
         code_point_item_type r;
         bit                  has_result;
         r          = '0;
         has_result = 1'b0;
         if (pending != '0) begin
            // any byte counts as a continuation; keep only its low 6 bits
            grown   = {partial, c[5:0]};
            pending = pending - PendW'(1);
            if (pending == '0) begin
               partial      = '0;
               r.code_point = grown[CodeW-1:0];
               has_result   = 1'b1;
            end else begin
               partial = grown[PartialW-1:0];
            end
         end else begin
            unique case (classify_lead(c))
               LEAD_ASCII: begin
                  r.code_point = CodeW'(c);
                  has_result   = 1'b1;
               end
               LEAD_TWO: begin
                  pending = PendW'(1);
                  partial = PartialW'(c & Lead2Bits);
               end
               LEAD_THREE: begin
                  pending = PendW'(2);
                  partial = PartialW'(c & Lead3Bits);
               end
               LEAD_FOUR: begin
                  pending = PendW'(3);
                  partial = PartialW'(c & Lead4Bits);
               end
               default: begin
                  // stray lead byte: skip
               end
            endcase
         end
         if (last) begin
            // string ends inside a sequence or on a stray byte: drop the tail
            if (!has_result) begin
               r.truncated = 1'b1;
            end
            r.string_end = 1'b1;
            has_result   = 1'b1;
            pending      = '0;
            partial      = '0;
         end
         if (has_result) begin
            decoded_fifo = {decoded_fifo, r};
         end
      endfunction

      task match_result(input logic [CodeW-1:0] code_point, input logic string_end,
                        input logic truncated);
         code_point_item_type want;
         if (decoded_fifo.size() == 0) begin
            report($sformatf("unexpected result cp=%06h end=%b trunc=%b",
                             code_point, string_end, truncated));
         end else begin
            want = decoded_fifo.pop_front();
            if (code_point !== want.code_point) begin
               report($sformatf("code_point %06h, want %06h", code_point,
                                want.code_point));
            end
            if (string_end !== want.string_end) begin
               report($sformatf("string_end %b, want %b", string_end, want.string_end));
            end
            if (truncated !== want.truncated) begin
               report($sformatf("truncated %b, want %b", truncated, want.truncated));
            end
         end
      endtask
   endclass

   localparam int unsigned ByteTarget = 1800;

   logic clock;
   logic reset;

   u8d_req_if req_ch ();
   u8d_rsp_if rsp_ch ();

   utf8_byte_stream_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   utf8_decode_tracker_type tracker = new();
   bit                      calm;
   int                      bytes_sent;

   // Bit 8 flags the last byte of a string.
   logic [ByteW:0] directed_bytes [25] = '{
      9'h000, 9'h07F,
      9'h0C0, 9'h080,
      9'h0DF, 9'h0FF,
      9'h0EF, 9'h0BF, 9'h03F,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h080, 9'h0FF, 9'h0F8,
      9'h0F0, 9'h080, 9'h180,
      9'h1E0,
      9'h1BF,
      9'h0C2, 9'h141,
      9'h141,
      9'h1F8
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [ByteW-1:0] c, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= c;
      req_ch.final_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.take_byte(c, last);
      bytes_sent++;
   endtask

   task automatic send_string(input bit noisy);
      logic [ByteW-1:0] bytes[$];
      int               chars;
      int               kind;
      int               conts;
      chars = $urandom_range(1, 6);
      for (int i = 0; i < chars; i++) begin
         kind  = $urandom_range(0, 9);
         conts = 0;
         if (kind == 9 && noisy) begin
            bytes = {bytes, ByteW'($urandom_range(0, 255))};
         end else if (kind <= 2 || kind == 9) begin
            bytes = {bytes, ByteW'($urandom_range(0, 127))};
         end else if (kind <= 4) begin
            bytes = {bytes, {3'b110, 5'($urandom)}};
            conts = 1;
         end else if (kind <= 6) begin
            bytes = {bytes, {4'b1110, 4'($urandom)}};
            conts = 2;
         end else begin
            bytes = {bytes, {5'b11110, 3'($urandom)}};
            conts = 3;
         end
         for (int j = 0; j < conts; j++) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
               bytes = {bytes, ByteW'($urandom_range(0, 255))};
            end else begin
               bytes = {bytes, {2'b10, 6'($urandom)}};
            end
         end
      end
      // cut the string short somewhere
      if (noisy && $urandom_range(0, 2) == 0) begin
         bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
      end
      foreach (bytes[i]) begin
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            tracker.match_result(rsp_ch.code_point, rsp_ch.string_end, rsp_ch.truncated);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall = pick_gap();
            end
         end
      end
   end

   initial begin : req_side
      int strings;
      int drain;
      strings    = 0;
      drain      = 0;
      bytes_sent = 0;
      calm       = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.final_byte <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) begin
         send_byte(directed_bytes[i][ByteW-1:0], directed_bytes[i][ByteW]);
      end

      while (bytes_sent < ByteTarget) begin
         // switch between runs with and without idle cycles
         if (strings % 40 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         send_string($urandom_range(0, 4) == 0);
         strings++;
      end
      req_ch.valid <= 1'b0;

      while (tracker.decoded_fifo.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      if (tracker.decoded_fifo.size() != 0) begin
         tracker.report($sformatf("%0d results never arrived", tracker.decoded_fifo.size()));
      end
      repeat (4) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
